// ===== sv/adcwe_pkg.sv =====
// ----------------------------------------------------------------------------
// adcwe_pkg: shared types and constants
// Payload structs, defaults and register map for the DC removal and window
// energy block.
// ----------------------------------------------------------------------------
package adcwe_pkg;

    localparam int WINDOW_LENGTH_DEF = 160;
    localparam int CAL_SKIP_DEF      = 500;
    localparam int CAL_LENGTH_DEF    = 500;

    localparam int SAMPLE_W       = 16;
    localparam int SAMPLE_MAG_MAX = 32768;
    localparam int INTENSITY_W    = 23;
    localparam logic [INTENSITY_W-1:0] INTENSITY_MAX = '1;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_MODE = '0;

    typedef struct packed {
        logic [7:0] raw_high;
        logic [7:0] raw_low;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]    corrected_sample;
        logic        [INTENSITY_W-1:0] intensity;
        logic                          intensity_valid;
        logic        [SAMPLE_W-1:0]    dc_offset;
        logic                          dc_updated;
    } out_item_t;

    // Per-transaction decode of the sample index
    typedef struct packed {
        logic restart;
        logic win_valid;
        logic cal_first;
        logic cal_mid;
        logic cal_last;
    } item_flags_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] dc_offset;
        logic                dc_updated;
    } cal_result_t;

endpackage

// ===== sv/adcwe_ctl.sv =====
// ----------------------------------------------------------------------------
// adcwe_ctl: sample index and ring pointer
// Tracks the index since restart and the history pointer, and decodes the
// window and calibration phases of each accepted transaction.
// ----------------------------------------------------------------------------
module adcwe_ctl #(
    parameter int WINDOW_LENGTH = adcwe_pkg::WINDOW_LENGTH_DEF,
    parameter int CAL_SKIP      = adcwe_pkg::CAL_SKIP_DEF,
    parameter int CAL_LENGTH    = adcwe_pkg::CAL_LENGTH_DEF,
    parameter int PTR_W         = $clog2(WINDOW_LENGTH)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic                   restart,
    output logic [PTR_W-1:0]       ptr_cur,
    output adcwe_pkg::item_flags_t flags
);

    localparam int CAL_END   = CAL_SKIP + CAL_LENGTH;
    localparam int IDX_LIMIT = ((WINDOW_LENGTH > CAL_END) ? WINDOW_LENGTH : CAL_END) + 1;
    localparam int IDX_W     = $clog2(IDX_LIMIT + 1);

    logic [IDX_W-1:0] idx_reg, idx_next, idx_cur;
    logic [PTR_W-1:0] ptr_reg, ptr_next;

    always_comb begin
        idx_cur = restart ? '0 : idx_reg;
        ptr_cur = restart ? '0 : ptr_reg;
        // saturate once every compare below has settled
        idx_next = (idx_cur == IDX_W'(IDX_LIMIT)) ? idx_cur : idx_cur + IDX_W'(1);
        ptr_next = (ptr_cur == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : ptr_cur + PTR_W'(1);

        flags.restart   = restart;
        flags.win_valid = idx_cur >= IDX_W'(WINDOW_LENGTH);
        flags.cal_first = idx_cur == IDX_W'(CAL_SKIP);
        flags.cal_mid   = (idx_cur > IDX_W'(CAL_SKIP)) && (idx_cur < IDX_W'(CAL_END));
        flags.cal_last  = idx_cur == IDX_W'(CAL_END);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            ptr_reg <= '0;
        end else if (accept) begin
            idx_reg <= idx_next;
            ptr_reg <= ptr_next;
        end
    end

endmodule

// ===== sv/adcwe_ring.sv =====
// ----------------------------------------------------------------------------
// adcwe_ring: magnitude history
// One write port, one read port with registered data.
// ----------------------------------------------------------------------------
module adcwe_ring #(
    parameter int DEPTH  = adcwe_pkg::WINDOW_LENGTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [adcwe_pkg::SAMPLE_W-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [adcwe_pkg::SAMPLE_W-1:0] wr_data
);

    logic [adcwe_pkg::SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

// ===== sv/adcwe_cal.sv =====
// ----------------------------------------------------------------------------
// adcwe_cal: DC offset calibration
// Accumulates corrected samples over the calibration span and folds their
// mean, truncated toward zero, into the offset with clamping.
// ----------------------------------------------------------------------------
module adcwe_cal #(
    parameter int CAL_LENGTH = adcwe_pkg::CAL_LENGTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           mode,
    input  logic                           advance,
    input  adcwe_pkg::item_flags_t         flags,
    input  logic [adcwe_pkg::SAMPLE_W-1:0] diff,
    output logic [adcwe_pkg::SAMPLE_W-1:0] offset,
    output adcwe_pkg::cal_result_t         result
);

    localparam int SW    = adcwe_pkg::SAMPLE_W;
    localparam int MAG_W = $clog2(CAL_LENGTH * adcwe_pkg::SAMPLE_MAG_MAX + 1);
    localparam int SUM_W = MAG_W + 1;
    localparam int LOG_D = $clog2(CAL_LENGTH);
    localparam int SHIFT = MAG_W + LOG_D;
    // round-up reciprocal: exact floor division for every MAG_W-bit magnitude
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(CAL_LENGTH) - 64'd1) / 64'(CAL_LENGTH);
    localparam logic [MAG_W:0] RECIP = RECIP_FULL[MAG_W:0];

    logic [SUM_W-1:0] sum_reg;
    logic [SW-1:0]    offset_reg;
    logic [SUM_W-1:0] diff_ext, sum_abs;
    logic             sum_neg;
    logic [MAG_W-1:0] sum_mag;
    logic [2*MAG_W:0] prod;
    logic [SW-1:0]    quot;
    logic [SW+1:0]    delta, off_sum;
    logic [SW-1:0]    off_clamped;
    logic             upd;

    assign diff_ext = {{(SUM_W-SW){diff[SW-1]}}, diff};
    assign sum_neg  = sum_reg[SUM_W-1];
    assign sum_abs  = sum_neg ? (SUM_W'(0) - sum_reg) : sum_reg;
    assign sum_mag  = sum_abs[MAG_W-1:0];
    assign prod     = {{(MAG_W+1){1'b0}}, sum_mag} * {{MAG_W{1'b0}}, RECIP};
    assign quot     = prod[SHIFT +: SW];

    always_comb begin
        delta   = sum_neg ? ((SW+2)'(0) - {2'b00, quot}) : {2'b00, quot};
        off_sum = {2'b00, offset_reg} + delta;
        if (off_sum[SW+1]) begin
            off_clamped = '0;
        end else if (off_sum[SW]) begin
            off_clamped = '1;
        end else begin
            off_clamped = off_sum[SW-1:0];
        end
    end

    assign upd               = mode && flags.cal_last;
    assign offset            = offset_reg;
    assign result.dc_offset  = upd ? off_clamped : offset_reg;
    assign result.dc_updated = upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            sum_reg    <= '0;
        end else if (advance && mode) begin
            if (flags.cal_first) begin
                sum_reg <= diff_ext;
            end else if (flags.cal_mid) begin
                sum_reg <= sum_reg + diff_ext;
            end
            if (flags.cal_last) begin
                offset_reg <= off_clamped;
            end
        end
    end

endmodule

// ===== sv/audio_dc_removal_window_energy.sv =====
// ----------------------------------------------------------------------------
// audio_dc_removal_window_energy: DC offset removal and window energy
// Pipeline: two register stages; an accepted transaction enters the input register
// and moves to the result register on m_ when it advances.
// Throughput: one transaction per cycle; the history ring is read on accept
// and written as the transaction advances, so a full window never stalls the
// stream. A stalled result holds the input once both registers are full.
// Reset (aresetn low, synchronous): offset, index, pointer, sums and mode go
// to zero; history contents are not cleared and are used only once written.
// ----------------------------------------------------------------------------
module audio_dc_removal_window_energy #(
    parameter int WINDOW_LENGTH = adcwe_pkg::WINDOW_LENGTH_DEF,
    parameter int CAL_SKIP      = adcwe_pkg::CAL_SKIP_DEF,
    parameter int CAL_LENGTH    = adcwe_pkg::CAL_LENGTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  adcwe_pkg::in_item_t                s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output adcwe_pkg::out_item_t               m_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [adcwe_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [adcwe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [adcwe_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int SW    = adcwe_pkg::SAMPLE_W;
    localparam int IW    = adcwe_pkg::INTENSITY_W;
    localparam int PTR_W = $clog2(WINDOW_LENGTH);
    localparam int WS_W  = $clog2(WINDOW_LENGTH * adcwe_pkg::SAMPLE_MAG_MAX + 1);
    localparam int SAT_W = (WS_W > IW) ? WS_W : IW;
    localparam int AW    = adcwe_pkg::APB_ADDR_W;

    // configuration
    logic mode_reg;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[AW-1:2] == adcwe_pkg::REG_MODE;
    assign prdata  = reg_sel ? {{(adcwe_pkg::APB_DATA_W-1){1'b0}}, mode_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            mode_reg <= pwdata[0];
        end
    end

    // handshake
    logic accept, advance;
    logic a_valid_reg, m_valid_reg;

    assign advance = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !a_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // index and pointer decode
    logic [PTR_W-1:0]       ptr_cur;
    adcwe_pkg::item_flags_t flags_cur;

    adcwe_ctl #(
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .CAL_SKIP      (CAL_SKIP),
        .CAL_LENGTH    (CAL_LENGTH),
        .PTR_W         (PTR_W)
    ) u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .restart (s_data.restart),
        .ptr_cur (ptr_cur),
        .flags   (flags_cur)
    );

    // input register
    logic [SW-1:0]          a_raw_reg;
    logic [PTR_W-1:0]       a_ptr_reg;
    adcwe_pkg::item_flags_t a_flags_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (accept) begin
            a_valid_reg <= 1'b1;
        end else if (advance) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_raw_reg   <= {s_data.raw_high, s_data.raw_low};
            a_ptr_reg   <= ptr_cur;
            a_flags_reg <= flags_cur;
        end
    end

    // correction
    logic [SW-1:0] offset, diff, mag;

    assign diff = a_raw_reg - offset;
    assign mag  = diff[SW-1] ? (SW'(0) - diff) : diff;

    // history ring: read the oldest entry on accept, overwrite it on advance
    logic [SW-1:0] old_mag;

    adcwe_ring #(
        .DEPTH  (WINDOW_LENGTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (ptr_cur),
        .rd_data (old_mag),
        .wr_en   (advance),
        .wr_addr (a_ptr_reg),
        .wr_data (mag)
    );

    adcwe_pkg::cal_result_t cal_res;

    adcwe_cal #(
        .CAL_LENGTH (CAL_LENGTH)
    ) u_cal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mode    (mode_reg),
        .advance (advance),
        .flags   (a_flags_reg),
        .diff    (diff),
        .offset  (offset),
        .result  (cal_res)
    );

    // window sum
    logic [WS_W-1:0]  ws_reg, ws_next, ws_base, ws_drop;
    logic [SAT_W-1:0] ws_wide;
    logic [IW-1:0]    intensity;

    always_comb begin
        ws_base = a_flags_reg.restart ? '0 : ws_reg;
        ws_drop = a_flags_reg.win_valid ? WS_W'(old_mag) : '0;
        ws_next = ws_base - ws_drop + WS_W'(mag);
        ws_wide = SAT_W'(ws_base);
        if (!a_flags_reg.win_valid) begin
            intensity = '0;
        end else if (ws_wide > SAT_W'(adcwe_pkg::INTENSITY_MAX)) begin
            intensity = adcwe_pkg::INTENSITY_MAX;
        end else begin
            intensity = ws_wide[IW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg <= '0;
        end else if (advance) begin
            ws_reg <= ws_next;
        end
    end

    // result register
    adcwe_pkg::out_item_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.corrected_sample <= signed'(diff);
            m_data_reg.intensity        <= intensity;
            m_data_reg.intensity_valid  <= a_flags_reg.win_valid;
            m_data_reg.dc_offset        <= cal_res.dc_offset;
            m_data_reg.dc_updated       <= cal_res.dc_updated;
        end
    end

    assign m_data = m_data_reg;

endmodule

// ===== sv/adcwe_checker.sv =====
// ----------------------------------------------------------------------------
// adcwe_checker: port-level checks
// Watches the result channel and the configuration port of the top level.
// ----------------------------------------------------------------------------
module adcwe_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input adcwe_pkg::out_item_t             m_data,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [adcwe_pkg::APB_ADDR_W-1:0] paddr,
    input logic [adcwe_pkg::APB_DATA_W-1:0] pwdata,
    input logic                             pready
);

    localparam int AW = adcwe_pkg::APB_ADDR_W;

    logic                           mode_reg;
    logic [adcwe_pkg::SAMPLE_W-1:0] last_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= 1'b0;
            last_offset_reg <= '0;
        end else begin
            if (psel && penable && pwrite && pready &&
                    paddr[AW-1:2] == adcwe_pkg::REG_MODE) begin
                mode_reg <= pwdata[0];
            end
            if (m_valid && m_ready) begin
                last_offset_reg <= m_data.dc_offset;
            end
        end
    end

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_intensity_gate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.intensity_valid |-> m_data.intensity == '0)
        else $error("intensity reported before a full window");

    a_offset_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.dc_updated |-> m_data.dc_offset == last_offset_reg)
        else $error("offset moved without a calibration update");

    a_update_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.dc_updated |-> mode_reg)
        else $error("offset updated outside calibrate mode");

endmodule

bind audio_dc_removal_window_energy adcwe_checker u_adcwe_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready)
);
